@@ hdl/float32_approx_equal_macros.svh @@
// Assertion macros shared by the float32 approximate-equality block.
`ifndef FLOAT32_APPROX_EQUAL_MACROS_SVH
`define FLOAT32_APPROX_EQUAL_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define FAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a signal holds its value in the cycle after a condition.
`define FAE_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

@@ hdl/fae_pkg.sv @@
// Package with types, constants and helper functions of the float32 comparator.
package fae_pkg;

  localparam logic [30:0] ExpAllOnes = 31'h7F800000;
  localparam logic [31:0] QuietNan   = 32'h7FC00000;
  localparam logic [31:0] PosInf     = 32'h7F800000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ABS_TOL = 2'd0,
    CFG_REL_TOL = 2'd1,
    CFG_ULP_LIM = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] abs_tol;
    logic [31:0] rel_tol;
    logic [31:0] ulp_limit;
  } cfg_t;

  // Load enables of the three internal pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Leading zero count of a 28-bit word (28 when the word is zero).
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (v[i] && !found) begin
        n     = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zero count of a 48-bit word (48 when the word is zero).
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (v[i] && !found) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return f[30:0] > ExpAllOnes;
  endfunction

  // Ordered x <= y on float32 patterns; false when either side is NaN.
  function automatic logic fle(input logic [31:0] x, input logic [31:0] y);
    logic r;
    if (is_nan(x) || is_nan(y)) begin
      r = 1'b0;
    end else if (x[30:0] == 31'd0 && y[30:0] == 31'd0) begin
      r = 1'b1;
    end else if (x[31] != y[31]) begin
      r = x[31];
    end else if (!x[31]) begin
      r = x[30:0] <= y[30:0];
    end else begin
      r = x[30:0] >= y[30:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/fae_if.sv @@
// Valid/ready channel interfaces of the float32 comparator.
interface fae_pair_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] value_a;
  logic [31:0] value_b;
  modport source (output valid, mode, value_a, value_b, input ready);
  modport sink (input valid, mode, value_a, value_b, output ready);
endinterface

interface fae_result_if;
  logic valid;
  logic ready;
  logic alike;
  modport source (output valid, alike, input ready);
  modport sink (input valid, alike, output ready);
endinterface

interface fae_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/fae_cfg.sv @@
// Configuration register file holding the three tolerances.
module fae_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  fae_cfg_if.sink       cfg_i,
  output fae_pkg::cfg_t regs_o
);
  import fae_pkg::*;

  cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  // Write one register per beat; the unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.abs_tol   <= '0;
      regs_q.rel_tol   <= '0;
      regs_q.ulp_limit <= 32'd4;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ABS_TOL: regs_q.abs_tol   <= cfg_i.data;
        CFG_REL_TOL: regs_q.rel_tol   <= cfg_i.data;
        CFG_ULP_LIM: regs_q.ulp_limit <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/fae_sub.sv @@
// Pipelined float32 subtractor giving the rounded magnitude |a - b|.
module fae_sub (
  input  logic               clk_i,
  input  fae_pkg::stage_en_t en_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output logic [31:0]        diff_o
);
  import fae_pkg::*;

  // Stage 1: order operands by magnitude and classify specials.
  logic [30:0] ma, mb, mx, my;
  logic        swap, nan_a, nan_b, inf_a, inf_b, eff_sub;
  logic [7:0]  ex_eff, ey_eff;
  logic [23:0] s1_mx_d, s1_my_d;
  logic [23:0] s1_mx_q, s1_my_q;
  logic [7:0]  s1_ex_q, s1_d_q;
  logic        s1_sub_q, s1_nan_q, s1_inf_q;

  always_comb begin
    ma      = a_i[30:0];
    mb      = b_i[30:0];
    swap    = mb > ma;
    mx      = swap ? mb : ma;
    my      = swap ? ma : mb;
    nan_a   = ma > ExpAllOnes;
    nan_b   = mb > ExpAllOnes;
    inf_a   = ma == ExpAllOnes;
    inf_b   = mb == ExpAllOnes;
    eff_sub = a_i[31] == b_i[31];
    ex_eff  = (mx[30:23] == 8'd0) ? 8'd1 : mx[30:23];
    ey_eff  = (my[30:23] == 8'd0) ? 8'd1 : my[30:23];
    s1_mx_d = {mx[30:23] != 8'd0, mx[22:0]};
    s1_my_d = {my[30:23] != 8'd0, my[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_mx_q  <= s1_mx_d;
      s1_my_q  <= s1_my_d;
      s1_ex_q  <= ex_eff;
      s1_d_q   <= ex_eff - ey_eff;
      s1_sub_q <= eff_sub;
      s1_nan_q <= nan_a || nan_b || (inf_a && inf_b && eff_sub);
      s1_inf_q <= (inf_a || inf_b) && !(nan_a || nan_b || (inf_a && inf_b && eff_sub));
    end
  end

  // Stage 2: align the smaller operand with guard, round and sticky bits, then add.
  logic [4:0]  dc;
  logic [53:0] wide;
  logic [26:0] aligned;
  logic [27:0] s2_sum_d, s2_sum_q;
  logic [7:0]  s2_ex_q;
  logic        s2_nan_q, s2_inf_q;

  always_comb begin
    dc       = (s1_d_q > 8'd27) ? 5'd27 : s1_d_q[4:0];
    wide     = {s1_my_q, 3'b000, 27'd0} >> dc;
    aligned  = {wide[53:28], wide[27] | (|wide[26:0])};
    s2_sum_d = s1_sub_q ? ({1'b0, s1_mx_q, 3'b000} - {1'b0, aligned})
                        : ({1'b0, s1_mx_q, 3'b000} + {1'b0, aligned});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_sum_q <= s2_sum_d;
      s2_ex_q  <= s1_ex_q;
      s2_nan_q <= s1_nan_q;
      s2_inf_q <= s1_inf_q;
    end
  end

  // Stage 3: normalize, stopping at the smallest exponent for denormals.
  logic [4:0]  lz;
  logic [7:0]  shl;
  logic [26:0] s3_n_d, s3_n_q;
  logic [8:0]  s3_e_d, s3_e_q;
  logic        s3_zero_q, s3_nan_q, s3_inf_q;

  always_comb begin
    lz  = lzc28(s2_sum_q);
    shl = ({3'b000, lz} - 8'd1 < s2_ex_q - 8'd1) ? ({3'b000, lz} - 8'd1) : (s2_ex_q - 8'd1);
    if (s2_sum_q[27]) begin
      s3_n_d = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
      s3_e_d = {1'b0, s2_ex_q} + 9'd1;
    end else begin
      s3_n_d = s2_sum_q[26:0] << shl;
      s3_e_d = {1'b0, s2_ex_q} - {1'b0, shl};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_n_q    <= s3_n_d;
      s3_e_q    <= s3_e_d;
      s3_zero_q <= s2_sum_q == 28'd0;
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
    end
  end

  // Round to nearest even and pack; a rounding carry moves into the exponent.
  logic [7:0]  enc;
  logic        up;
  logic [31:0] packed_mag;

  always_comb begin
    enc        = s3_n_q[26] ? s3_e_q[7:0] : 8'd0;
    up         = s3_n_q[2] && (s3_n_q[1] || s3_n_q[0] || s3_n_q[3]);
    packed_mag = {1'b0, enc, s3_n_q[25:3]} + {31'd0, up};
    if (s3_nan_q) begin
      diff_o = QuietNan;
    end else if (s3_inf_q || s3_e_q >= 9'd255) begin
      diff_o = PosInf;
    end else if (s3_zero_q) begin
      diff_o = 32'd0;
    end else begin
      diff_o = packed_mag;
    end
  end

endmodule

@@ hdl/fae_mul.sv @@
// Pipelined float32 multiplier forming max(|a|,|b|) times the relative tolerance.
module fae_mul (
  input  logic               clk_i,
  input  fae_pkg::stage_en_t en_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  input  logic [31:0]        rel_i,
  output logic [31:0]        bound_o
);
  import fae_pkg::*;

  // Stage 1: pick the larger magnitude (a wins on NaN) and unpack both factors.
  logic [30:0] ma, mb, ml, mr;
  logic        nan_l, nan_r, inf_l, inf_r, zero_l, zero_r, nan_p;
  logic [23:0] s1_ml_q, s1_mr_q;
  logic [7:0]  s1_el_q, s1_er_q;
  logic        s1_nan_q, s1_inf_q, s1_zero_q, s1_sign_q;

  always_comb begin
    ma     = a_i[30:0];
    mb     = b_i[30:0];
    ml     = (ma <= ExpAllOnes && mb <= ExpAllOnes && mb > ma) ? mb : ma;
    mr     = rel_i[30:0];
    nan_l  = ml > ExpAllOnes;
    nan_r  = mr > ExpAllOnes;
    inf_l  = ml == ExpAllOnes;
    inf_r  = mr == ExpAllOnes;
    zero_l = ml == 31'd0;
    zero_r = mr == 31'd0;
    nan_p  = nan_l || nan_r || (inf_l && zero_r) || (inf_r && zero_l);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_ml_q   <= {ml[30:23] != 8'd0, ml[22:0]};
      s1_mr_q   <= {mr[30:23] != 8'd0, mr[22:0]};
      s1_el_q   <= (ml[30:23] == 8'd0) ? 8'd1 : ml[30:23];
      s1_er_q   <= (mr[30:23] == 8'd0) ? 8'd1 : mr[30:23];
      s1_nan_q  <= nan_p;
      s1_inf_q  <= (inf_l || inf_r) && !nan_p;
      s1_zero_q <= (zero_l || zero_r) && !nan_p;
      s1_sign_q <= rel_i[31];
    end
  end

  // Stage 2: mantissa product and exponent sum.
  logic [47:0] s2_p_q;
  logic [8:0]  s2_esum_q;
  logic        s2_nan_q, s2_inf_q, s2_zero_q, s2_sign_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_p_q    <= s1_ml_q * s1_mr_q;
      s2_esum_q <= {1'b0, s1_el_q} + {1'b0, s1_er_q};
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_zero_q <= s1_zero_q;
      s2_sign_q <= s1_sign_q;
    end
  end

  // Stage 3: bring the leading one to the top and work out the exponent.
  logic [5:0]         lz;
  logic [47:0]        s3_pn_q;
  logic signed [10:0] s3_er_q;
  logic               s3_nan_q, s3_inf_q, s3_zero_q, s3_sign_q;

  assign lz = lzc48(s2_p_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_pn_q   <= s2_p_q << lz;
      s3_er_q   <= $signed({2'b00, s2_esum_q}) - 11'sd126 - $signed({5'd0, lz});
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
      s3_zero_q <= s2_zero_q || (s2_p_q == 48'd0);
      s3_sign_q <= s2_sign_q;
    end
  end

  // Denormalize small results, then round to nearest even and pack.
  logic               normal;
  logic signed [10:0] sh_full;
  logic [5:0]         shc;
  logic [95:0]        wide;
  logic [23:0]        m;
  logic               guard, sticky, up;
  logic [7:0]         enc;
  logic [31:0]        mag;

  always_comb begin
    normal  = s3_er_q >= 11'sd1;
    sh_full = 11'sd1 - s3_er_q;
    shc     = normal ? 6'd0 : ((sh_full > 11'sd48) ? 6'd48 : sh_full[5:0]);
    wide    = {s3_pn_q, 48'd0} >> shc;
    m       = wide[95:72];
    guard   = wide[71];
    sticky  = |wide[70:0];
    up      = guard && (sticky || m[0]);
    enc     = normal ? s3_er_q[7:0] : 8'd0;
    mag     = {1'b0, enc, m[22:0]} + {31'd0, up};
    if (s3_nan_q) begin
      bound_o = QuietNan;
    end else if (s3_inf_q || s3_er_q >= 11'sd255) begin
      bound_o = {s3_sign_q, PosInf[30:0]};
    end else if (s3_zero_q) begin
      bound_o = {s3_sign_q, 31'd0};
    end else begin
      bound_o = {s3_sign_q, mag[30:0]};
    end
  end

endmodule

@@ hdl/float32_approx_equal.sv @@
// Top level of the float32 approximate-equality comparator.
//
// The block compares two float32 bit patterns and answers whether they are approximately
// equal, using the absolute tolerance first and then either a relative tolerance (mode 0)
// or a distance in units in the last place (mode 1). It takes one operand pair per beat in
// every cycle unless a stalled output holds a full pipeline, and returns one result beat per
// pair, in order. The path has four register stages: unpack and order the operands, align
// and add beside the 24 by 24 mantissa product, normalize, and a round-and-compare stage
// that feeds the output register. An accepted pair passes through these stages in order,
// and its verdict waits in the output register until it is taken. A stalled output holds
// the pipeline stage by stage, so bubbles are squeezed out before any upstream stage stops.
// Configuration beats are always taken and should be sent while the pipeline is empty.
module float32_approx_equal (
  input  logic      clk_i,
  input  logic      rst_ni,
  fae_pair_if.sink   pair_i,
  fae_result_if.source result_o,
  fae_cfg_if.sink    cfg_i
);
  import fae_pkg::*;

  cfg_t      cfg;
  stage_en_t en;
  logic      en_out;
  logic      v1_q, v2_q, v3_q, out_valid_q, alike_q;
  logic [31:0] diff, bound;

  fae_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (cfg)
  );

  // A stage loads when it is empty or the stage after it moves on.
  assign en_out      = !out_valid_q || result_o.ready;
  assign en.s3       = !v3_q || en_out;
  assign en.s2       = !v2_q || en.s3;
  assign en.s1       = !v1_q || en.s2;
  assign pair_i.ready = en.s1;

  fae_sub u_sub (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (pair_i.value_a),
    .b_i    (pair_i.value_b),
    .diff_o (diff)
  );

  fae_mul u_mul (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (pair_i.value_a),
    .b_i     (pair_i.value_b),
    .rel_i   (cfg.rel_tol),
    .bound_o (bound)
  );

  // Integer distance of the bit patterns; only meaningful when the signs agree.
  logic [31:0] raw_dist;
  logic [30:0] dist_d;
  assign raw_dist = pair_i.value_a - pair_i.value_b;
  assign dist_d   = raw_dist[31] ? 31'(-raw_dist) : raw_dist[30:0];

  logic        s1_mode_q, s2_mode_q, s3_mode_q;
  logic        s1_sdif_q, s2_sdif_q, s3_sdif_q;
  logic [30:0] s1_dist_q, s2_dist_q, s3_dist_q;

  // Side data for the ULP test travels with the arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      s1_mode_q <= pair_i.mode;
      s1_sdif_q <= pair_i.value_a[31] ^ pair_i.value_b[31];
      s1_dist_q <= dist_d;
    end
    if (en.s2) begin
      s2_mode_q <= s1_mode_q;
      s2_sdif_q <= s1_sdif_q;
      s2_dist_q <= s1_dist_q;
    end
    if (en.s3) begin
      s3_mode_q <= s2_mode_q;
      s3_sdif_q <= s2_sdif_q;
      s3_dist_q <= s2_dist_q;
    end
  end

  // Valid bits of each stage and of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= pair_i.valid;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en_out) out_valid_q <= v3_q;
    end
  end

  // Final decision: absolute test, then the relative or the ULP test.
  logic ulp_ok, alike_d;
  always_comb begin
    ulp_ok = !s3_sdif_q && !cfg.ulp_limit[31] && (s3_dist_q <= cfg.ulp_limit[30:0]);
    if (fle(diff, cfg.abs_tol)) begin
      alike_d = 1'b1;
    end else if (!s3_mode_q) begin
      alike_d = fle(diff, bound);
    end else begin
      alike_d = ulp_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) alike_q <= alike_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.alike = alike_q;

  `include "float32_approx_equal_macros.svh"

  `FAE_ASSERT(a_accept_fills_s1, pair_i.valid && pair_i.ready |=> v1_q, "accepted beat lost")
  `FAE_ASSERT(a_stall_holds_s3, out_valid_q && !result_o.ready && v3_q |=> v3_q,
              "stage 3 dropped a beat during an output stall")
  `FAE_ASSERT_HOLD(a_stall_holds_mode, out_valid_q && !result_o.ready && v3_q, s3_mode_q,
                   "stage 3 payload changed during an output stall")
  `FAE_ASSERT(a_full_not_ready, v1_q && v2_q && v3_q && out_valid_q && !result_o.ready
              |-> !pair_i.ready, "full pipeline took a new beat")

endmodule

@@ dv/float32_approx_equal_test.sv @@
// Testbench for the float32 approximate-equality comparator with its own arithmetic model.
module float32_approx_equal_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fae_pkg::*;

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam logic ModeRel = 1'b0;
  localparam logic ModeUlp = 1'b1;
  localparam int Drain = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fae_pair_if   pair ();
  fae_result_if result ();
  fae_cfg_if    cfg ();

  float32_approx_equal uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pair_i  (pair.sink),
    .result_o(result.source),
    .cfg_i   (cfg.sink)
  );

  // Shadow copy of the configuration registers.
  logic [31:0] abs_tol_q = 32'h0;
  logic [31:0] rel_tol_q = 32'h0;
  logic [31:0] ulp_lim_q = 32'd4;

  logic alike_due[$];
  int   errors = 0;
  bit   quiet = 1'b0;

  always #10 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("float32_approx_equal: mismatch");
    $finish;
  end

  // Float helpers: split a finite pattern into an integer mantissa and a power of two.
  function automatic logic f_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 23'd0;
  endfunction

  function automatic logic f_inf(logic [31:0] x);
    return x[30:0] == 31'h7F800000;
  endfunction

  function automatic logic [23:0] f_mant(logic [31:0] x);
    return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
  endfunction

  function automatic int f_exp(logic [31:0] x);
    return (x[30:23] == 8'd0) ? -149 : int'(x[30:23]) - 150;
  endfunction

  // Ordering key; both zeros map to the same key.
  function automatic longint f_key(logic [31:0] x);
    return x[31] ? -longint'(x[30:0]) : longint'(x[30:0]);
  endfunction

  function automatic logic f_le(logic [31:0] x, logic [31:0] y);
    return !f_nan(x) && !f_nan(y) && f_key(x) <= f_key(y);
  endfunction

  // Rounds mag * 2**e to float32, nearest even, subnormals kept, overflow to infinity.
  function automatic logic [31:0] round_to_f32(logic sgn, logic [299:0] mag, int e);
    int msb;
    int q;
    int sh;
    logic [299:0] kept;
    logic [24:0] m;
    logic guard;
    logic sticky;
    msb = -1;
    for (int i = 0; i < 300; i++) if (mag[i]) msb = i;
    if (msb < 0) return {sgn, 31'd0};
    q = msb + e - 23;
    if (q < -149) q = -149;
    sh = q - e;
    guard = 1'b0;
    sticky = 1'b0;
    if (sh <= 0) begin
      kept = mag << (-sh);
    end else begin
      kept = mag >> sh;
      guard = mag[sh-1];
      sticky = |(mag & ((300'd1 << (sh - 1)) - 300'd1));
    end
    m = kept[24:0];
    if (guard && (sticky || m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      q++;
    end
    if (q > 104) return {sgn, PosInf[30:0]};
    if (!m[23]) return {sgn, 8'd0, m[22:0]};
    return {sgn, 8'(q + 150), m[22:0]};
  endfunction

  // Magnitude of the rounded difference a - b.
  function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic [299:0] wa;
    logic [299:0] wb;
    logic [299:0] mag;
    if (f_nan(a) || f_nan(b)) return QuietNan;
    if (f_inf(a) && f_inf(b)) return (a[31] == b[31]) ? QuietNan : PosInf;
    if (f_inf(a) || f_inf(b)) return PosInf;
    wa = 300'(f_mant(a)) << (f_exp(a) + 149);
    wb = 300'(f_mant(b)) << (f_exp(b) + 149);
    if (a[31] != b[31]) mag = wa + wb;
    else mag = (wa > wb) ? wa - wb : wb - wa;
    return round_to_f32(1'b0, mag, -149);
  endfunction

  // Rounded product of two float32 patterns.
  function automatic logic [31:0] f_mul(logic [31:0] x, logic [31:0] y);
    logic sgn;
    logic [47:0] p;
    sgn = x[31] ^ y[31];
    if (f_nan(x) || f_nan(y)) return QuietNan;
    if ((f_inf(x) && y[30:0] == 31'd0) || (f_inf(y) && x[30:0] == 31'd0)) return QuietNan;
    if (f_inf(x) || f_inf(y)) return {sgn, PosInf[30:0]};
    p = f_mant(x) * f_mant(y);
    return round_to_f32(sgn, 300'(p), f_exp(x) + f_exp(y));
  endfunction

  // Expected verdict for one operand pair under the current register values.
  function automatic logic predict_alike(logic mode, logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] big;
    longint gap;
    d = abs_diff(a, b);
    if (f_le(d, abs_tol_q)) return 1'b1;
    if (mode == ModeRel) begin
      ma = {1'b0, a[30:0]};
      mb = {1'b0, b[30:0]};
      big = (!f_nan(ma) && !f_nan(mb) && f_key(mb) > f_key(ma)) ? mb : ma;
      return f_le(d, f_mul(big, rel_tol_q));
    end
    if (a[31] != b[31]) return 1'b0;
    gap = longint'($signed(a)) - longint'($signed(b));
    if (gap < 0) gap = -gap;
    return gap <= longint'($signed(ulp_lim_q));
  endfunction

  task automatic report(string what);
    $display("ERROR %0t: %s", $realtime, what);
    errors++;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && result.valid && result.ready) begin
      if (alike_due.size() == 0) begin
        report($sformatf("result beat alike=%0b with nothing expected", result.alike));
      end else begin
        want = alike_due.pop_front();
        if (result.alike !== want)
          report($sformatf("alike=%0b, expected %0b", result.alike, want));
      end
    end
  end

  initial begin
    forever begin
      result.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Sends one operand pair and records its expected verdict at the accepting edge.
  task automatic send_pair(logic mode, logic [31:0] a, logic [31:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pair.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    pair.valid <= 1'b1;
    pair.mode <= mode;
    pair.value_a <= a;
    pair.value_b <= b;
    do @(posedge clk_i); while (!pair.ready);
    alike_due.push_back(predict_alike(mode, a, b));
  endtask

  task automatic wait_empty();
    pair.valid <= 1'b0;
    while (alike_due.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      CFG_ABS_TOL: abs_tol_q = data;
      CFG_REL_TOL: rel_tol_q = data;
      CFG_ULP_LIM: ulp_lim_q = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] at, logic [31:0] rt, logic [31:0] ul);
    wait_empty();
    write_reg(CFG_ABS_TOL, at);
    write_reg(CFG_REL_TOL, rt);
    write_reg(CFG_ULP_LIM, ul);
    cfg.valid <= 1'b0;
  endtask

  // Interesting operand patterns: zeros, subnormals, extremes, infinities, NaNs.
  function automatic logic [31:0] edge_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h0;
      1: v = 32'h1;
      2: v = 32'h007FFFFF;
      3: v = 32'h00800000;
      4: v = 32'h7F7FFFFF;
      5: v = PosInf;
      6: v = QuietNan;
      7: v = 32'h7F800001;
      8: v = 32'h3F800000;
      default: v = {9'h0FF, 23'($urandom)};
    endcase
    v[31] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  // Operand b near a in bits, or scaled slightly, so the tolerance tests decide.
  function automatic logic [31:0] near_value(logic [31:0] a);
    logic [31:0] b;
    case ($urandom_range(0, 5))
      0: b = a + $urandom_range(0, 8);
      1: b = a - $urandom_range(0, 8);
      2: b = a + $urandom_range(0, 5000) - 2500;
      3: b = a ^ (32'h1 << $urandom_range(0, 22));
      4: b = a ^ 32'h80000000;
      default: b = a + ($urandom_range(0, 3) << $urandom_range(0, 24));
    endcase
    return b;
  endfunction

  task automatic test_directed();
    send_pair(ModeRel, 32'h0, 32'h80000000);
    send_pair(ModeUlp, 32'h80000000, 32'h0);
    send_pair(ModeRel, QuietNan, QuietNan);
    send_pair(ModeUlp, QuietNan, 32'h7FC00002);
    send_pair(ModeUlp, 32'hFFFFFFFF, 32'hFFFFFFFE);
    send_pair(ModeRel, PosInf, PosInf);
    send_pair(ModeUlp, PosInf, 32'h7F7FFFFF);
    send_pair(ModeRel, 32'h7F7FFFFF, 32'hFF7FFFFF);
    send_pair(ModeUlp, 32'h7F7FFFFF, 32'hFF7FFFFF);
    send_pair(ModeRel, 32'h1, 32'h2);
    send_pair(ModeUlp, 32'h3F800000, 32'h3F800004);
    send_pair(ModeUlp, 32'h3F800000, 32'h3F800005);
    send_pair(ModeRel, 32'h3F800000, 32'h3F800001);
    send_pair(ModeRel, 32'hFFFFFFFF, 32'h00000000);
  endtask

  task automatic test_tolerances();
    set_config(32'h3A83126F, 32'h3727C5AC, 32'd0);
    test_directed();
    write_cfg_unused();
    set_config(QuietNan, QuietNan, 32'hFFFFFFFF);
    test_directed();
    set_config(PosInf, 32'hBF800000, 32'h7FFFFFFF);
    test_directed();
    set_config(32'hFF800000, PosInf, 32'h80000000);
    test_directed();
  endtask

  // A write to the unused index must leave every register as it was.
  task automatic write_cfg_unused();
    wait_empty();
    write_reg(CfgUnused, 32'h12345678);
    cfg.valid <= 1'b0;
    send_pair(ModeUlp, 32'h3F800000, 32'h3F800001);
  endtask

  task automatic test_random(int count);
    logic [31:0] a;
    logic [31:0] b;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          a = $urandom;
          b = $urandom;
        end
        2: begin
          a = edge_value();
          b = edge_value();
        end
        3: begin
          a = edge_value();
          b = near_value(a);
        end
        default: begin
          a = $urandom;
          b = near_value(a);
        end
      endcase
      send_pair(1'($urandom_range(0, 1)), a, b);
    end
  endtask

  task automatic test_phases();
    set_config(32'h0, 32'h3400_0000, 32'd16);
    test_random(250);
    set_config(32'h3727C5AC, 32'h3A83126F, 32'd1000);
    test_random(250);
    set_config(32'h0, 32'h0, 32'h7FFFFFFF);
    test_random(250);
    set_config($urandom, $urandom, $urandom);
    test_random(250);
    set_config(32'h7F7FFFFF, 32'h7F7FFFFF, 32'h80000000);
    test_random(200);
    set_config(32'h00000001, 32'h30000000, 32'd2);
    test_random(250);
    set_config(32'h0, 32'h3727C5AC, 32'd4);
    quiet = 1'b1;
    test_random(250);
  endtask

  initial begin
    pair.valid <= 1'b0;
    pair.mode <= ModeRel;
    pair.value_a <= 32'h0;
    pair.value_b <= 32'h0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_ABS_TOL;
    cfg.data <= 32'h0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tolerances();
    test_phases();
    wait_empty();
    if (errors == 0) begin
      $display("float32_approx_equal: match");
    end else begin
      $display("float32_approx_equal: mismatch");
    end
    $finish;
  end
endmodule
